// ----- design/dau_pkg.sv -----
// ----------------------------------------------------------------------------
// dau_pkg: shared types and constants of the dihedral angle unit
// Request payloads, internal word widths, the arctangent table and the
// shift-fit helper used by the normalizing stages.
// ----------------------------------------------------------------------------
`default_nettype none

package dau_pkg;

  // Coordinate format: signed, 12 fraction bits.
  localparam int unsigned COORD_BITS = 24;
  localparam int unsigned DIFF_W     = COORD_BITS + 1;

  // Prescaled differences stay below 2^24 in magnitude.
  localparam int unsigned PRE_BITS = 24;
  localparam int unsigned PD_W     = PRE_BITS + 1;
  localparam int unsigned N_W      = 2 * PD_W + 1;

  // Normals are brought below 2^20.
  localparam int unsigned NORM_BITS = 20;
  localparam int unsigned NS_W      = NORM_BITS + 1;
  localparam int unsigned DC_W      = 2 * NS_W + 1;

  // Dot and cross products are brought below 2^30.
  localparam int unsigned DCS_BITS = 30;
  localparam int unsigned DCS_W    = DCS_BITS + 1;

  // Integer square root of the squared cross product length.
  localparam int unsigned SQ_W     = 2 * DCS_W;
  localparam int unsigned SQ_ITERS = SQ_W / 2;
  localparam int unsigned ROOT_W   = SQ_ITERS;
  localparam int unsigned REM_W    = ROOT_W + 2;
  localparam int unsigned TERM_W   = ROOT_W + 1;

  // CORDIC: angles with 30 fraction bits.
  localparam int unsigned CORDIC_STEPS = 30;
  localparam int unsigned ANG_W        = 34;
  localparam int unsigned XY_W         = 35;
  localparam logic signed [ANG_W-1:0] ANG_PI = 34'sd3373259426;

  // Output format: radians with 13 fraction bits.
  localparam int unsigned TORS_W      = 16;
  localparam int          TORSION_MAX = 25736;
  localparam int unsigned RND_SHIFT   = 17;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_y;
    logic signed [COORD_BITS-1:0] a_z;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_y;
    logic signed [COORD_BITS-1:0] b_z;
    logic signed [COORD_BITS-1:0] c_x;
    logic signed [COORD_BITS-1:0] c_y;
    logic signed [COORD_BITS-1:0] c_z;
    logic signed [COORD_BITS-1:0] d_x;
    logic signed [COORD_BITS-1:0] d_y;
    logic signed [COORD_BITS-1:0] d_z;
  } in_t;

  typedef struct packed {
    logic signed [TORS_W-1:0] torsion;
    logic                     degenerate;
  } out_t;

  // Per-item control that travels alongside the datapath.
  typedef struct packed {
    logic vld;
    logic deg;
  } tag_t;

  // Smallest right shift that brings a magnitude below 2^bits.
  function automatic logic [6:0] fit_k(input logic [63:0] m, input logic [6:0] bits);
    logic [6:0] len;
    len = '0;
    for (int i = 0; i < 64; i++) begin
      if (m[i]) begin
        len = 7'(i + 1);
      end
    end
    return (len > bits) ? 7'(len - bits) : 7'd0;
  endfunction

  // atan(2^-i) with 30 fraction bits.
  function automatic logic signed [ANG_W-1:0] atan_q30(input int unsigned i);
    logic [31:0] t;
    case (i)
      0:       t = 32'h3243F6A8;
      1:       t = 32'h1DAC6705;
      2:       t = 32'h0FADBAFC;
      3:       t = 32'h07F56EA6;
      4:       t = 32'h03FEAB76;
      5:       t = 32'h01FFD55B;
      6:       t = 32'h00FFFAAA;
      7:       t = 32'h007FFF55;
      8:       t = 32'h003FFFEA;
      9:       t = 32'h001FFFFD;
      10:      t = 32'h000FFFFF;
      11:      t = 32'h0007FFFF;
      12:      t = 32'h0003FFFF;
      13:      t = 32'h0001FFFF;
      14:      t = 32'h0000FFFF;
      15:      t = 32'h00007FFF;
      16:      t = 32'h00003FFF;
      17:      t = 32'h00001FFF;
      18:      t = 32'h00000FFF;
      19:      t = 32'h000007FF;
      20:      t = 32'h000003FF;
      21:      t = 32'h000001FF;
      22:      t = 32'h000000FF;
      23:      t = 32'h0000007F;
      24:      t = 32'h0000003F;
      25:      t = 32'h0000001F;
      26:      t = 32'h0000000F;
      27:      t = 32'h00000008;
      28:      t = 32'h00000004;
      29:      t = 32'h00000002;
      default: t = 32'h00000000;
    endcase
    return $signed(ANG_W'(t));
  endfunction

endpackage

`default_nettype wire

// ----- design/dau_cordic.sv -----
// ----------------------------------------------------------------------------
// dau_cordic: pipelined CORDIC arctangent
// Vectoring-mode atan2(y, x) with one micro-rotation per register stage and
// quadrant folding in a front stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dau_cordic (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  dau_pkg::tag_t                       tag_i,
  input  logic signed [dau_pkg::TERM_W-1:0]   y_i,
  input  logic signed [dau_pkg::DCS_W-1:0]    x_i,
  output dau_pkg::tag_t                       tag_o,
  output logic signed [dau_pkg::ANG_W-1:0]    ang_o
);

  localparam int unsigned N  = dau_pkg::CORDIC_STEPS;
  localparam int unsigned XW = dau_pkg::XY_W;
  localparam int unsigned AW = dau_pkg::ANG_W;

  logic signed [XW-1:0] x_q [0:N-1];
  logic signed [XW-1:0] y_q [0:N-1];
  logic signed [AW-1:0] z_q [0:N];
  logic                 sp_q  [0:N];
  logic                 spi_q [0:N];
  logic                 deg_q [0:N];
  logic                 vld_q [0:N];

  logic signed [XW-1:0] x0_d, y0_d;
  logic signed [AW-1:0] z0_d;
  logic                 yz_d, xn_d;

  // Front stage: fold the left half plane onto the right one.
  always_comb begin
    yz_d = (y_i == '0);
    xn_d = x_i[dau_pkg::DCS_W-1];
    x0_d = XW'(x_i);
    y0_d = XW'(y_i);
    z0_d = '0;
    if (!yz_d && xn_d) begin
      x0_d = -XW'(x_i);
      y0_d = -XW'(y_i);
      z0_d = y_i[dau_pkg::TERM_W-1] ? -dau_pkg::ANG_PI : dau_pkg::ANG_PI;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]   <= x0_d;
      y_q[0]   <= y0_d;
      z_q[0]   <= z0_d;
      sp_q[0]  <= yz_d;
      spi_q[0] <= xn_d;
      deg_q[0] <= tag_i.deg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= N; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en_i) begin
      vld_q[0] <= tag_i.vld;
      for (int i = 1; i <= N; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    logic ypos;
    assign ypos = !y_q[i][XW-1];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        z_q[i+1]   <= ypos ? z_q[i] + dau_pkg::atan_q30(i) : z_q[i] - dau_pkg::atan_q30(i);
        sp_q[i+1]  <= sp_q[i];
        spi_q[i+1] <= spi_q[i];
        deg_q[i+1] <= deg_q[i];
      end
    end

    if (i < N - 1) begin : g_xy
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (ypos) begin
            x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
            y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          end else begin
            x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
            y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          end
        end
      end
    end
  end

  // A zero sine term gives 0 or pi directly.
  assign ang_o = sp_q[N] ? (spi_q[N] ? dau_pkg::ANG_PI : AW'(0)) : z_q[N];
  assign tag_o = '{vld: vld_q[N], deg: deg_q[N]};

endmodule

`default_nettype wire

// ----- design/dihedral_angle_unit.sv -----
// ----------------------------------------------------------------------------
// dihedral_angle_unit: signed torsion angle of four 3-D points
// Forms the plane normals of a-b-c and b-c-d, normalizes them and returns
// atan2(sign * |n1 x n2|, n1 . n2) in radians with 13 fraction bits.
// ----------------------------------------------------------------------------
//
//   Channel | Handshake                      | Payload
//   --------+--------------------------------+------------------------------
//   in      | in_valid_i / in_ready_o        | in_req_i  (twelve coordinates)
//   out     | out_valid_o / out_ready_i      | out_req_o (torsion, degenerate)
//
// One request is accepted every clock cycle while the output is not stalled.
// Most of the depth comes from the 31-stage square root, one digit per stage,
// and the 31-stage CORDIC: a folding stage, then one micro-rotation per stage.
// Reset clears only the valid bits; the pipeline is empty after reset.
// When the output register holds a result that is not taken, every stage
// holds and in_ready_o drops, so nothing is lost or repeated.
`default_nettype none

module dihedral_angle_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  dau_pkg::in_t  in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output dau_pkg::out_t out_req_o
);

  localparam int unsigned DW   = dau_pkg::DIFF_W;
  localparam int unsigned PW   = dau_pkg::PD_W;
  localparam int unsigned MW   = 2 * PW;
  localparam int unsigned NW   = dau_pkg::N_W;
  localparam int unsigned SW   = dau_pkg::NS_W;
  localparam int unsigned QW   = 2 * SW;
  localparam int unsigned CW   = dau_pkg::DC_W;
  localparam int unsigned DSW  = dau_pkg::DCS_W;
  localparam int unsigned QSW  = dau_pkg::SQ_W;
  localparam int unsigned SPW  = PW + DSW;
  localparam int unsigned SSW  = SPW + 2;
  localparam int unsigned NIT  = dau_pkg::SQ_ITERS;
  localparam int unsigned RTW  = dau_pkg::ROOT_W;
  localparam int unsigned RMW  = dau_pkg::REM_W;
  localparam int unsigned AW   = dau_pkg::ANG_W;
  localparam int unsigned KPW  = $clog2(DW + 1);
  localparam int unsigned KNW  = $clog2(NW + 1);
  localparam int unsigned KCW  = $clog2(CW + 1);
  localparam int unsigned NVLD = 13;

  localparam logic signed [AW:0] RND_HALF = (AW+1)'(2 ** (dau_pkg::RND_SHIFT - 1));
  localparam logic signed [AW:0] T_MAX    = (AW+1)'(dau_pkg::TORSION_MAX);
  localparam logic signed [AW:0] T_MIN    = -T_MAX;

  // The whole pipeline advances unless a finished result is waiting.
  logic          en;
  logic          out_vld_q;
  dau_pkg::out_t out_q, out_d;

  assign en = !out_vld_q || out_ready_i;

  // Valid bits of the front stages.
  logic vld_q [0:NVLD-1];

  // Stage registers.
  dau_pkg::in_t          in0_q;
  logic signed [DW-1:0]  d1_q [0:8];
  logic signed [DW-1:0]  d2_q [0:8];
  logic [KPW-1:0]        kp2_q;
  logic signed [PW-1:0]  p3_q [0:8];
  logic signed [MW-1:0]  m4_q [0:11];
  logic signed [PW-1:0]  v4_q [0:2], v5_q [0:2], v6_q [0:2], v7_q [0:2];
  logic signed [PW-1:0]  v8_q [0:2], v9_q [0:2], v10_q [0:2], v11_q [0:2];
  logic                  vz4_q;
  logic signed [NW-1:0]  n5_q [0:5];
  logic signed [NW-1:0]  n6_q [0:5];
  logic [KNW-1:0]        kn6_q [0:1];
  logic signed [SW-1:0]  ns7_q [0:5];
  logic signed [QW-1:0]  q8_q [0:8];
  logic signed [CW-1:0]  dc9_q [0:3];
  logic signed [CW-1:0]  dc10_q [0:3];
  logic [KCW-1:0]        kc10_q;
  logic signed [DSW-1:0] dcs11_q [0:3];
  logic [QSW-1:0]        sqp12_q [0:2];
  logic signed [SPW-1:0] sp12_q [0:2];
  logic signed [DSW-1:0] ds12_q;
  logic                  deg5_q, deg6_q, deg7_q, deg8_q, deg9_q, deg10_q, deg11_q, deg12_q;

  // Square root pipeline; index 0 is loaded from the product sums.
  logic [RMW-1:0]        rem_q  [0:NIT-1];
  logic [QSW-1:0]        nr_q   [0:NIT-1];
  logic [RTW-1:0]        root_q [0:NIT];
  logic                  sneg_q [0:NIT];
  logic signed [DSW-1:0] ds_q   [0:NIT];
  logic                  sdeg_q [0:NIT];
  logic                  svld_q [0:NIT];

  // Next values.
  logic signed [DW-1:0]  d1_d [0:8];
  logic [DW-1:0]         mor_p;
  logic [KPW-1:0]        kp_d;
  logic signed [MW-1:0]  m4_d [0:11];
  logic signed [NW-1:0]  n5_d [0:5];
  logic [NW-1:0]         mor_n [0:1];
  logic signed [QW-1:0]  q8_d [0:8];
  logic signed [CW-1:0]  dc9_d [0:3];
  logic [CW-1:0]         mor_c;
  logic [QSW-1:0]        sqp_d [0:2];
  logic signed [SPW-1:0] sp_d [0:2];
  logic [QSW-1:0]        sq_sum;
  logic signed [SSW-1:0] s_sum;

  // Differences u = a - b, v = c - b (the axis) and w = c - d.
  always_comb begin
    d1_d[0] = DW'(in0_q.a_x) - DW'(in0_q.b_x);
    d1_d[1] = DW'(in0_q.a_y) - DW'(in0_q.b_y);
    d1_d[2] = DW'(in0_q.a_z) - DW'(in0_q.b_z);
    d1_d[3] = DW'(in0_q.c_x) - DW'(in0_q.b_x);
    d1_d[4] = DW'(in0_q.c_y) - DW'(in0_q.b_y);
    d1_d[5] = DW'(in0_q.c_z) - DW'(in0_q.b_z);
    d1_d[6] = DW'(in0_q.c_x) - DW'(in0_q.d_x);
    d1_d[7] = DW'(in0_q.c_y) - DW'(in0_q.d_y);
    d1_d[8] = DW'(in0_q.c_z) - DW'(in0_q.d_z);
  end

  // A common prescale keeps every difference below 2^24. The OR of the
  // magnitudes has the same leading one as their maximum.
  always_comb begin
    mor_p = '0;
    for (int i = 0; i < 9; i++) begin
      mor_p = mor_p | (d1_q[i][DW-1] ? $unsigned(DW'(-d1_q[i])) : $unsigned(d1_q[i]));
    end
    kp_d = KPW'(dau_pkg::fit_k(64'(mor_p), 7'(dau_pkg::PRE_BITS)));
  end

  // Partial products of n1 = u x v and n2 = v x w.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      m4_d[2*j]   = MW'(p3_q[(j+1)%3])   * MW'(p3_q[3+(j+2)%3]);
      m4_d[2*j+1] = MW'(p3_q[(j+2)%3])   * MW'(p3_q[3+(j+1)%3]);
      m4_d[6+2*j] = MW'(p3_q[3+(j+1)%3]) * MW'(p3_q[6+(j+2)%3]);
      m4_d[7+2*j] = MW'(p3_q[3+(j+2)%3]) * MW'(p3_q[6+(j+1)%3]);
    end
    for (int j = 0; j < 6; j++) begin
      n5_d[j] = NW'(m4_q[2*j]) - NW'(m4_q[2*j+1]);
    end
  end

  // Each normal gets its own shift to bring it below 2^20.
  always_comb begin
    mor_n[0] = '0;
    mor_n[1] = '0;
    for (int j = 0; j < 3; j++) begin
      mor_n[0] = mor_n[0] |
                 (n5_q[j][NW-1] ? $unsigned(NW'(-n5_q[j])) : $unsigned(n5_q[j]));
      mor_n[1] = mor_n[1] |
                 (n5_q[3+j][NW-1] ? $unsigned(NW'(-n5_q[3+j])) : $unsigned(n5_q[3+j]));
    end
  end

  // Products of n1 . n2 and n1 x n2.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      q8_d[j]     = QW'(ns7_q[j]) * QW'(ns7_q[3+j]);
      q8_d[3+2*j] = QW'(ns7_q[(j+1)%3]) * QW'(ns7_q[3+(j+2)%3]);
      q8_d[4+2*j] = QW'(ns7_q[(j+2)%3]) * QW'(ns7_q[3+(j+1)%3]);
    end
    dc9_d[0] = CW'(q8_q[0]) + CW'(q8_q[1]) + CW'(q8_q[2]);
    for (int j = 0; j < 3; j++) begin
      dc9_d[1+j] = CW'(q8_q[3+2*j]) - CW'(q8_q[4+2*j]);
    end
  end

  // Dot and cross products share one shift to stay below 2^30.
  always_comb begin
    mor_c = '0;
    for (int i = 0; i < 4; i++) begin
      mor_c = mor_c | (dc9_q[i][CW-1] ? $unsigned(CW'(-dc9_q[i])) : $unsigned(dc9_q[i]));
    end
  end

  // Squared length of the cross product and the sign of axis . cross.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sqp_d[j] = $unsigned(QSW'(dcs11_q[1+j]) * QSW'(dcs11_q[1+j]));
      sp_d[j]  = SPW'(v11_q[j]) * SPW'(dcs11_q[1+j]);
    end
    sq_sum = sqp12_q[0] + sqp12_q[1] + sqp12_q[2];
    s_sum  = SSW'(sp12_q[0]) + SSW'(sp12_q[1]) + SSW'(sp12_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NVLD; i++) begin
        vld_q[i] <= 1'b0;
      end
      for (int i = 0; i <= NIT; i++) begin
        svld_q[i] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i < NVLD; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
      svld_q[0] <= vld_q[NVLD-1];
      for (int i = 1; i <= NIT; i++) begin
        svld_q[i] <= svld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in0_q <= in_req_i;
      d1_q  <= d1_d;
      d2_q  <= d1_q;
      kp2_q <= kp_d;
      for (int i = 0; i < 9; i++) begin
        p3_q[i] <= PW'(d2_q[i] >>> kp2_q);
      end
      m4_q  <= m4_d;
      vz4_q <= (p3_q[3] == '0) && (p3_q[4] == '0) && (p3_q[5] == '0);
      for (int j = 0; j < 3; j++) begin
        v4_q[j] <= p3_q[3+j];
      end
      n5_q   <= n5_d;
      deg5_q <= vz4_q ||
                ((n5_d[0] == '0) && (n5_d[1] == '0) && (n5_d[2] == '0)) ||
                ((n5_d[3] == '0) && (n5_d[4] == '0) && (n5_d[5] == '0));
      v5_q     <= v4_q;
      n6_q     <= n5_q;
      kn6_q[0] <= KNW'(dau_pkg::fit_k(64'(mor_n[0]), 7'(dau_pkg::NORM_BITS)));
      kn6_q[1] <= KNW'(dau_pkg::fit_k(64'(mor_n[1]), 7'(dau_pkg::NORM_BITS)));
      v6_q     <= v5_q;
      deg6_q   <= deg5_q;
      for (int j = 0; j < 3; j++) begin
        ns7_q[j]   <= SW'(n6_q[j] >>> kn6_q[0]);
        ns7_q[3+j] <= SW'(n6_q[3+j] >>> kn6_q[1]);
      end
      v7_q    <= v6_q;
      deg7_q  <= deg6_q;
      q8_q    <= q8_d;
      v8_q    <= v7_q;
      deg8_q  <= deg7_q;
      dc9_q   <= dc9_d;
      v9_q    <= v8_q;
      deg9_q  <= deg8_q;
      dc10_q  <= dc9_q;
      kc10_q  <= KCW'(dau_pkg::fit_k(64'(mor_c), 7'(dau_pkg::DCS_BITS)));
      v10_q   <= v9_q;
      deg10_q <= deg9_q;
      for (int i = 0; i < 4; i++) begin
        dcs11_q[i] <= DSW'(dc10_q[i] >>> kc10_q);
      end
      v11_q   <= v10_q;
      deg11_q <= deg10_q;
      sqp12_q <= sqp_d;
      sp12_q  <= sp_d;
      ds12_q  <= dcs11_q[0];
      deg12_q <= deg11_q;
      // Entry of the square root pipeline.
      rem_q[0]  <= '0;
      nr_q[0]   <= sq_sum;
      root_q[0] <= '0;
      sneg_q[0] <= s_sum[SSW-1];
      ds_q[0]   <= ds12_q;
      sdeg_q[0] <= deg12_q;
    end
  end

  // Square root, one result bit per stage (restoring digit recurrence).
  for (genvar j = 0; j < NIT; j++) begin : g_sqrt
    logic [RMW+1:0] cur, trial;
    logic           ge;

    assign cur   = {rem_q[j], nr_q[j][QSW-1 -: 2]};
    assign trial = (RMW+2)'({root_q[j], 2'b01});
    assign ge    = (cur >= trial);

    always_ff @(posedge clk_i) begin
      if (en) begin
        root_q[j+1] <= {root_q[j][RTW-2:0], ge};
        sneg_q[j+1] <= sneg_q[j];
        ds_q[j+1]   <= ds_q[j];
        sdeg_q[j+1] <= sdeg_q[j];
      end
    end

    if (j < NIT - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en) begin
          rem_q[j+1] <= ge ? RMW'(cur - trial) : RMW'(cur);
          nr_q[j+1]  <= {nr_q[j][QSW-3:0], 2'b00};
        end
      end
    end
  end

  // Signed sine term and arctangent.
  logic signed [dau_pkg::TERM_W-1:0] term;
  dau_pkg::tag_t                     sq_tag, cor_tag;
  logic signed [AW-1:0]              cor_ang;

  assign term   = sneg_q[NIT] ? -$signed({1'b0, root_q[NIT]}) : $signed({1'b0, root_q[NIT]});
  assign sq_tag = '{vld: svld_q[NIT], deg: sdeg_q[NIT]};

  dau_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .tag_i  (sq_tag),
    .y_i    (term),
    .x_i    (ds_q[NIT]),
    .tag_o  (cor_tag),
    .ang_o  (cor_ang)
  );

  // Round to 13 fraction bits and saturate.
  logic signed [AW:0] rnd, tq, tsat;

  always_comb begin
    rnd  = (AW+1)'(cor_ang) + RND_HALF;
    tq   = rnd >>> dau_pkg::RND_SHIFT;
    tsat = tq;
    if (tq > T_MAX) begin
      tsat = T_MAX;
    end else if (tq < T_MIN) begin
      tsat = T_MIN;
    end
    out_d.degenerate = cor_tag.deg;
    out_d.torsion    = cor_tag.deg ? '0 : dau_pkg::TORS_W'(tsat);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= cor_tag.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign in_ready_o  = en;
  assign out_valid_o = out_vld_q;
  assign out_req_o   = out_q;

endmodule

`default_nettype wire

// ----- design/dau_checker.sv -----
// ----------------------------------------------------------------------------
// dau_checker: port-level assertions of the dihedral angle unit
// Watches the request channels and the result format over time.
// ----------------------------------------------------------------------------
`default_nettype none

module dau_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_ready_o,
  input wire dau_pkg::in_t  in_req_i,
  input wire logic          out_valid_o,
  input wire logic          out_ready_i,
  input wire dau_pkg::out_t out_req_o
);

  // A request that is not taken stays put.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_req_i))
    else $error("request changed while stalled");

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_req_o))
    else $error("result changed while stalled");

  // The input side is held back only by a waiting result.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow the output register");

  // A degenerate result carries a zero angle.
  a_degen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.degenerate |-> out_req_o.torsion == '0)
    else $error("degenerate result with nonzero angle");

  // The angle stays within plus or minus pi.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_req_o.torsion <= dau_pkg::TORSION_MAX) &&
                    (out_req_o.torsion >= -dau_pkg::TORSION_MAX))
    else $error("torsion out of range");

endmodule

bind dihedral_angle_unit dau_checker u_dau_checker (.*);

`default_nettype wire
